// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used in the peak accumulator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define TPPA_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TPPA_ASSERT_IMPL(name, clk, rst_n, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

// ===== design/tppa_pkg.sv =====
// ----------------------------------------------------------------------------
// Test pulse peak accumulator package
// Shared constants, codes and transaction types of the peak accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package tppa_pkg;

    localparam int ANODES_DEF  = 256;
    localparam int TIME_BINS   = 256;
    localparam int SAMPLE_BITS = 10;
    localparam int CMD_DEPTH   = 4;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam logic [9:0]  SAMPLE_MASK     = 10'((1 << SAMPLE_BITS) - 1);
    localparam logic [13:0] BASE_AT_RESET   = 14'd320;
    localparam logic [7:0]  NSIGMA_AT_RESET = 8'd48;
    localparam logic [7:0]  FIRST_AT_RESET  = 8'd0;
    localparam logic [7:0]  LAST_AT_RESET   = 8'd255;

    // Input function codes
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_NSIGMA    = 2'd0;
    localparam logic [1:0] CFG_FIRST_BIN = 2'd1;
    localparam logic [1:0] CFG_LAST_BIN  = 2'd2;

    typedef enum logic [2:0] {
        CMD_LOAD = 3'b001,
        CMD_READ = 3'b010,
        CMD_EVAL = 3'b100
    } t_kind;

    typedef struct packed {
        logic [7:0] nsigma;
        logic [7:0] first_bin;
        logic [7:0] last_bin;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  anode;
        logic [9:0]  peak;
        logic [7:0]  peak_bin;
        logic [13:0] baseline;
        logic [13:0] noise;
        logic        good;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

    typedef struct packed {
        logic                 clearing;
        logic [OUT_CNT_W-1:0] out_cnt;
    } t_bk_sts;

    typedef struct packed {
        logic [7:0]  anode_out;
        logic        hit;
        logic [13:0] peak_above_base;
        logic [7:0]  peak_bin;
        logic [31:0] sum_amplitude;
        logic [23:0] sum_time_bins;
        logic [15:0] hit_count;
        logic        anode_good;
    } t_res;

endpackage

`default_nettype wire

// ===== design/tppa_front.sv =====
// ----------------------------------------------------------------------------
// Peak accumulator front end
// Tracks the running peak of the current anode and turns accepted items
// into commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tppa_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tppa_pkg::t_cfg  i_cfg,
    input  wire logic            i_accept,
    input  wire logic [1:0]      i_func,
    input  wire logic [7:0]      i_anode,
    input  wire logic [7:0]      i_time_bin,
    input  wire logic [9:0]      i_sample,
    input  wire logic            i_last,
    input  wire logic [13:0]     i_cal_baseline,
    input  wire logic [13:0]     i_cal_noise,
    input  wire logic            i_cal_good,
    output logic                 o_push,
    output tppa_pkg::t_cmd       o_cmd
);

    logic [9:0] r_max;
    logic [7:0] r_bin;
    logic [9:0] n_max;
    logic [7:0] n_bin;
    logic [9:0] smp;
    logic       in_window;
    logic       is_sample;

    assign smp       = i_sample & tppa_pkg::SAMPLE_MASK;
    assign in_window = (i_time_bin >= i_cfg.first_bin) && (i_time_bin <= i_cfg.last_bin) &&
                       (int'(i_time_bin) < tppa_pkg::TIME_BINS);
    assign is_sample = i_accept && (i_func == tppa_pkg::FUNC_SAMPLE);

    // A tie keeps the earlier bin, so only a strictly larger sample replaces the peak.
    always_comb begin
        n_max = r_max;
        n_bin = r_bin;
        if (in_window && (smp > r_max)) begin
            n_max = smp;
            n_bin = i_time_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_bin <= '0;
        end else if (is_sample) begin
            if (i_last) begin
                r_max <= '0;
                r_bin <= '0;
            end else begin
                r_max <= n_max;
                r_bin <= n_bin;
            end
        end
    end

    always_comb begin
        o_cmd.anode    = i_anode;
        o_cmd.peak     = n_max;
        o_cmd.peak_bin = n_bin;
        o_cmd.baseline = i_cal_baseline;
        o_cmd.noise    = i_cal_noise;
        o_cmd.good     = i_cal_good;
        o_cmd.kind     = tppa_pkg::CMD_READ;
        o_push         = 1'b0;
        case (i_func)
            tppa_pkg::FUNC_LOAD: begin
                o_cmd.kind = tppa_pkg::CMD_LOAD;
                o_push     = i_accept;
            end
            tppa_pkg::FUNC_SAMPLE: begin
                o_cmd.kind = tppa_pkg::CMD_EVAL;
                o_push     = i_accept && i_last;
            end
            tppa_pkg::FUNC_READ: begin
                o_cmd.kind = tppa_pkg::CMD_READ;
                o_push     = i_accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tppa_queue.sv =====
// ----------------------------------------------------------------------------
// Peak accumulator command queue
// Short first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tppa_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire tppa_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output tppa_pkg::t_cmd       o_head,
    output tppa_pkg::t_q_sts     o_sts
);

    localparam int QW = (tppa_pkg::CMD_DEPTH > 1) ? $clog2(tppa_pkg::CMD_DEPTH) : 1;

    tppa_pkg::t_cmd r_mem [tppa_pkg::CMD_DEPTH];
    logic [QW-1:0]  r_wr;
    logic [QW-1:0]  r_rd;
    logic [QW:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QW'(tppa_pkg::CMD_DEPTH - 1)) ? '0 : r_wr + QW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QW'(tppa_pkg::CMD_DEPTH - 1)) ? '0 : r_rd + QW'(1);
            end
            r_cnt <= r_cnt + (QW + 1)'(i_push) - (QW + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_head      = r_mem[r_rd];
    assign o_sts.full  = (r_cnt == (QW + 1)'(tppa_pkg::CMD_DEPTH));
    assign o_sts.empty = (r_cnt == '0);

endmodule

`default_nettype wire

// ===== design/tppa_back.sv =====
// ----------------------------------------------------------------------------
// Peak accumulator back end
// Holds the per-anode calibration and accumulator memories, judges each
// closed anode against its threshold and queues the results.
// ----------------------------------------------------------------------------
`default_nettype none

module tppa_back #(
    parameter int ANODES = tppa_pkg::ANODES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tppa_pkg::t_cfg  i_cfg,
    input  wire tppa_pkg::t_cmd  i_head,
    input  wire logic            i_q_empty,
    output logic                 o_pop,
    input  wire logic            i_res_pop,
    output tppa_pkg::t_res       o_res,
    output tppa_pkg::t_bk_sts    o_sts
);

    localparam int AW = (ANODES > 1) ? $clog2(ANODES) : 1;
    localparam int OW = (tppa_pkg::OUT_DEPTH > 1) ? $clog2(tppa_pkg::OUT_DEPTH) : 1;
    localparam int CW = tppa_pkg::OUT_CNT_W;

    // Per-anode memories
    logic [13:0] r_mem_base  [ANODES];
    logic [13:0] r_mem_noise [ANODES];
    logic        r_mem_good  [ANODES];
    logic [31:0] r_mem_amp   [ANODES];
    logic [23:0] r_mem_bins  [ANODES];
    logic [15:0] r_mem_cnt   [ANODES];

    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;

    // Read stage
    logic           r_s1_vld;
    tppa_pkg::t_cmd r_s1;
    logic [13:0]    r_rd_base;
    logic [13:0]    r_rd_noise;
    logic           r_rd_good;
    logic [31:0]    r_rd_amp;
    logic [23:0]    r_rd_bins;
    logic [15:0]    r_rd_cnt;
    logic [21:0]    s1_prod;

    // Judge stage
    logic           r_s2_vld;
    tppa_pkg::t_cmd r_s2;
    logic [13:0]    r_s2_base;
    logic [21:0]    r_s2_prod;
    logic           r_s2_good;
    logic [31:0]    r_s2_amp;
    logic [23:0]    r_s2_bins;
    logic [15:0]    r_s2_cnt;

    logic          s1_writes;
    logic          s2_writes;
    logic          hazard;
    logic [CW:0]   in_flight;
    logic          w_pop;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    logic          s2_valid_an;
    logic [13:0]   peak4;
    logic [17:0]   peak8;
    logic [22:0]   thr8;
    logic          above;
    logic          s2_hit;
    logic          s2_load_wr;
    logic [13:0]   diff;
    logic [32:0]   amp_sum;
    logic [24:0]   bins_sum;
    logic [31:0]   amp_new;
    logic [23:0]   bins_new;
    logic [15:0]   cnt_new;
    logic          res_push;
    tppa_pkg::t_res s2_res;

    tppa_pkg::t_res r_out_mem [tppa_pkg::OUT_DEPTH];
    logic [OW-1:0]  r_out_wr;
    logic [OW-1:0]  r_out_rd;
    logic [CW-1:0]  r_out_cnt;

    // ------------------------------------------------------------------
    // Issue: a command that follows a write to the same anode waits until
    // that write has reached the memory.
    // ------------------------------------------------------------------
    assign s1_writes = r_s1_vld && (r_s1.kind != tppa_pkg::CMD_READ);
    assign s2_writes = r_s2_vld && (r_s2.kind != tppa_pkg::CMD_READ);
    assign hazard    = (s1_writes && (r_s1.anode == i_head.anode)) ||
                       (s2_writes && (r_s2.anode == i_head.anode));

    assign in_flight = (CW + 1)'(r_out_cnt) +
                       (CW + 1)'(r_s1_vld && (r_s1.kind != tppa_pkg::CMD_LOAD)) +
                       (CW + 1)'(r_s2_vld && (r_s2.kind != tppa_pkg::CMD_LOAD));

    assign w_pop = !r_clearing && !i_q_empty && !hazard &&
                   (in_flight < (CW + 1)'(tppa_pkg::OUT_DEPTH));
    assign o_pop = w_pop;

    assign rd_addr = AW'(i_head.anode);
    assign wr_addr = AW'(r_s2.anode);

    // ------------------------------------------------------------------
    // Clearing pass after reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == AW'(ANODES - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem_base[r_clr_idx]  <= tppa_pkg::BASE_AT_RESET;
            r_mem_noise[r_clr_idx] <= '0;
            r_mem_good[r_clr_idx]  <= 1'b1;
            r_mem_amp[r_clr_idx]   <= '0;
            r_mem_bins[r_clr_idx]  <= '0;
            r_mem_cnt[r_clr_idx]   <= '0;
        end else begin
            if (s2_load_wr) begin
                r_mem_base[wr_addr]  <= r_s2.baseline;
                r_mem_noise[wr_addr] <= r_s2.noise;
                r_mem_good[wr_addr]  <= r_s2.good;
            end
            if (s2_hit) begin
                r_mem_amp[wr_addr]  <= amp_new;
                r_mem_bins[wr_addr] <= bins_new;
                r_mem_cnt[wr_addr]  <= cnt_new;
            end
        end
        r_rd_base  <= r_mem_base[rd_addr];
        r_rd_noise <= r_mem_noise[rd_addr];
        r_rd_good  <= r_mem_good[rd_addr];
        r_rd_amp   <= r_mem_amp[rd_addr];
        r_rd_bins  <= r_mem_bins[rd_addr];
        r_rd_cnt   <= r_mem_cnt[rd_addr];
    end

    // ------------------------------------------------------------------
    // Pipeline
    // ------------------------------------------------------------------
    assign s1_prod = 22'(i_cfg.nsigma) * 22'(r_rd_noise);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_pop;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1      <= i_head;
        r_s2      <= r_s1;
        r_s2_base <= r_rd_base;
        r_s2_prod <= s1_prod;
        r_s2_good <= r_rd_good;
        r_s2_amp  <= r_rd_amp;
        r_s2_bins <= r_rd_bins;
        r_s2_cnt  <= r_rd_cnt;
    end

    // The threshold compare is exact in Q.8: peak << 8 against
    // (baseline << 4) + nsigma * noise.
    assign s2_valid_an = (int'(r_s2.anode) < ANODES);
    assign peak4       = {r_s2.peak, 4'b0000};
    assign peak8       = {r_s2.peak, 8'b0000_0000};
    assign thr8        = 23'({r_s2_base, 4'b0000}) + 23'(r_s2_prod);
    assign above       = (23'(peak8) > thr8) && (peak4 > r_s2_base);
    assign s2_hit      = r_s2_vld && (r_s2.kind == tppa_pkg::CMD_EVAL) && s2_valid_an &&
                         r_s2_good && above;
    assign s2_load_wr  = r_s2_vld && (r_s2.kind == tppa_pkg::CMD_LOAD) && s2_valid_an;
    assign diff        = peak4 - r_s2_base;

    assign amp_sum  = 33'(r_s2_amp) + 33'(diff);
    assign bins_sum = 25'(r_s2_bins) + 25'(r_s2.peak_bin);
    assign amp_new  = amp_sum[32] ? '1 : amp_sum[31:0];
    assign bins_new = bins_sum[24] ? '1 : bins_sum[23:0];
    assign cnt_new  = (r_s2_cnt == '1) ? r_s2_cnt : r_s2_cnt + 16'd1;

    always_comb begin
        s2_res.anode_out       = r_s2.anode;
        s2_res.hit             = s2_hit;
        s2_res.peak_above_base = s2_hit ? diff : '0;
        s2_res.peak_bin        = (r_s2.kind == tppa_pkg::CMD_EVAL) ? r_s2.peak_bin : '0;
        s2_res.sum_amplitude   = '0;
        s2_res.sum_time_bins   = '0;
        s2_res.hit_count       = '0;
        s2_res.anode_good      = 1'b0;
        if (s2_valid_an) begin
            s2_res.sum_amplitude = s2_hit ? amp_new : r_s2_amp;
            s2_res.sum_time_bins = s2_hit ? bins_new : r_s2_bins;
            s2_res.hit_count     = s2_hit ? cnt_new : r_s2_cnt;
            s2_res.anode_good    = r_s2_good;
        end
    end

    assign res_push = r_s2_vld && (r_s2.kind != tppa_pkg::CMD_LOAD);

    // ------------------------------------------------------------------
    // Result queue; issue reserves room for every result still in flight.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr  <= '0;
            r_out_rd  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (res_push) begin
                r_out_wr <= (r_out_wr == OW'(tppa_pkg::OUT_DEPTH - 1)) ? '0 : r_out_wr + OW'(1);
            end
            if (i_res_pop) begin
                r_out_rd <= (r_out_rd == OW'(tppa_pkg::OUT_DEPTH - 1)) ? '0 : r_out_rd + OW'(1);
            end
            r_out_cnt <= r_out_cnt + CW'(res_push) - CW'(i_res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_out_mem[r_out_wr] <= s2_res;
        end
    end

    assign o_res          = r_out_mem[r_out_rd];
    assign o_sts.clearing = r_clearing;
    assign o_sts.out_cnt  = r_out_cnt;

endmodule

`default_nettype wire

// ===== design/test_pulse_peak_accumulator.sv =====
// ----------------------------------------------------------------------------
// Test pulse peak accumulator
// Takes one detector sample per cycle while not full, anode by anode in
// time-bin order, and keeps the peak inside the configured bin window.
// When an anode's last sample arrives, a good anode whose peak passes
// baseline plus nsigma times noise adds its peak above baseline, peak bin
// and one event to saturating per-anode sums, and a peak result is queued.
// Calibration load and sum read items share the same input queue. The front
// end accepts one item every cycle while its four-entry command queue has
// room. The back end takes one command per cycle, when no hazard or full
// result queue holds it, through a read, multiply and judge pipeline over
// the per-anode memories; a command for the same anode as a load or anode
// end still in that pipeline waits for the memory write. After reset, full
// stays high while the memories are cleared to their reset contents;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module test_pulse_peak_accumulator #(
    parameter int ANODES = tppa_pkg::ANODES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    // Input queue
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_anode,
    input  wire logic [7:0]  i_time_bin,
    input  wire logic [9:0]  i_sample,
    input  wire logic        i_last,
    input  wire logic [13:0] i_cal_baseline,
    input  wire logic [13:0] i_cal_noise,
    input  wire logic        i_cal_good,
    // Result queue
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_anode_out,
    output logic             o_hit,
    output logic [13:0]      o_peak_above_base,
    output logic [7:0]       o_peak_bin,
    output logic [31:0]      o_sum_amplitude,
    output logic [23:0]      o_sum_time_bins,
    output logic [15:0]      o_hit_count,
    output logic             o_anode_good
);

    tppa_pkg::t_cfg    r_cfg;
    tppa_pkg::t_cmd    w_cmd;
    tppa_pkg::t_cmd    w_head;
    tppa_pkg::t_q_sts  w_q_sts;
    tppa_pkg::t_bk_sts w_bk_sts;
    tppa_pkg::t_res    w_res;
    logic              w_accept;
    logic              w_cmd_push;
    logic              w_cmd_pop;
    logic              w_res_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nsigma    <= tppa_pkg::NSIGMA_AT_RESET;
            r_cfg.first_bin <= tppa_pkg::FIRST_AT_RESET;
            r_cfg.last_bin  <= tppa_pkg::LAST_AT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tppa_pkg::CFG_NSIGMA:    r_cfg.nsigma    <= i_cfg_data;
                tppa_pkg::CFG_FIRST_BIN: r_cfg.first_bin <= i_cfg_data;
                tppa_pkg::CFG_LAST_BIN:  r_cfg.last_bin  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign full      = w_bk_sts.clearing || w_q_sts.full;
    assign w_accept  = push && !full;
    assign empty     = (w_bk_sts.out_cnt == '0);
    assign w_res_pop = pop && !empty;

    tppa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (w_accept),
        .i_func         (i_func),
        .i_anode        (i_anode),
        .i_time_bin     (i_time_bin),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .i_cal_baseline (i_cal_baseline),
        .i_cal_noise    (i_cal_noise),
        .i_cal_good     (i_cal_good),
        .o_push         (w_cmd_push),
        .o_cmd          (w_cmd)
    );

    tppa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_cmd_pop),
        .o_head  (w_head),
        .o_sts   (w_q_sts)
    );

    tppa_back #(
        .ANODES (ANODES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_head    (w_head),
        .i_q_empty (w_q_sts.empty),
        .o_pop     (w_cmd_pop),
        .i_res_pop (w_res_pop),
        .o_res     (w_res),
        .o_sts     (w_bk_sts)
    );

    assign o_anode_out       = w_res.anode_out;
    assign o_hit             = w_res.hit;
    assign o_peak_above_base = w_res.peak_above_base;
    assign o_peak_bin        = w_res.peak_bin;
    assign o_sum_amplitude   = w_res.sum_amplitude;
    assign o_sum_time_bins   = w_res.sum_time_bins;
    assign o_hit_count       = w_res.hit_count;
    assign o_anode_good      = w_res.anode_good;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TPPA_ASSERT_IMPL(a_cmd_push_room, i_clk, i_rst_n, w_cmd_push, !w_q_sts.full && !w_bk_sts.clearing, "command pushed without room")
    `TPPA_ASSERT_IMPL(a_cmd_pop_ready, i_clk, i_rst_n, w_cmd_pop, !w_q_sts.empty && !w_bk_sts.clearing, "command issued from empty queue or during clear")
    `TPPA_ASSERT_ALWAYS(a_out_bound, i_clk, i_rst_n, w_bk_sts.out_cnt <= tppa_pkg::OUT_CNT_W'(tppa_pkg::OUT_DEPTH), "result queue overflow")
    `TPPA_ASSERT_IMPL(a_clear_quiet, i_clk, i_rst_n, w_bk_sts.clearing, empty && w_q_sts.empty, "transaction in flight during memory clear")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Peak accumulator testbench
// Drives calibration loads, anode sample sequences and accumulator reads into
// the input queue. A scoreboard keeps its own copy of the calibration tables,
// window and sums, predicts every peak and read result, and compares each
// popped result field by field. Both queue sides idle at random, and the
// registers are rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         DRAIN_CYCLES = 12;
    localparam int         PHASE_ITEMS = 175;
    localparam int         PHASES = 6;

    class peak_sum_scoreboard;
        logic [7:0]  nsigma;
        logic [7:0]  first_bin;
        logic [7:0]  last_bin;
        logic [13:0] base_cal [256];
        logic [13:0] noise_cal [256];
        logic        good_cal [256];
        logic [31:0] amp_sum [256];
        logic [23:0] bin_sum [256];
        logic [15:0] evt_count [256];
        logic [9:0]  run_max;
        logic [7:0]  run_bin;
        tppa_pkg::t_res expected_peaks [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned hits_seen;

        function new();
            nsigma    = tppa_pkg::NSIGMA_AT_RESET;
            first_bin = tppa_pkg::FIRST_AT_RESET;
            last_bin  = tppa_pkg::LAST_AT_RESET;
            for (int i = 0; i < 256; i++) begin
                base_cal[i]  = tppa_pkg::BASE_AT_RESET;
                noise_cal[i] = '0;
                good_cal[i]  = 1'b1;
                amp_sum[i]   = '0;
                bin_sum[i]   = '0;
                evt_count[i] = '0;
            end
            run_max   = '0;
            run_bin   = '0;
            errors    = 0;
            checked   = 0;
            hits_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                tppa_pkg::CFG_NSIGMA:    nsigma = value;
                tppa_pkg::CFG_FIRST_BIN: first_bin = value;
                tppa_pkg::CFG_LAST_BIN:  last_bin = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_peaks.size();
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            errors++;
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        endtask

        function void accept_item(logic [1:0] func, logic [7:0] an, logic [7:0] tb,
                                  logic [9:0] smp, logic last, logic [13:0] cb,
                                  logic [13:0] cn, logic cg);
            tppa_pkg::t_res r;
            logic [13:0]    peak4;
            logic [31:0]    peak8;
            logic [31:0]    thr8;
            logic [13:0]    diff;
            logic [32:0]    acc;
            r = '0;
            if (func == tppa_pkg::FUNC_LOAD) begin
                base_cal[an]  = cb;
                noise_cal[an] = cn;
                good_cal[an]  = cg;
                return;
            end
            if (func == tppa_pkg::FUNC_READ) begin
                r.anode_out     = an;
                r.sum_amplitude = amp_sum[an];
                r.sum_time_bins = bin_sum[an];
                r.hit_count     = evt_count[an];
                r.anode_good    = good_cal[an];
                expected_peaks.push_back(r);
                return;
            end
            if (func != tppa_pkg::FUNC_SAMPLE) return;
            if (tb >= first_bin && tb <= last_bin && smp > run_max) begin
                run_max = smp;
                run_bin = tb;
            end
            if (!last) return;
            r.anode_out = an;
            r.peak_bin  = run_bin;
            if (good_cal[an]) begin
                peak4 = {run_max, 4'b0};
                peak8 = {14'b0, run_max, 8'b0};
                thr8  = {14'b0, base_cal[an], 4'b0} + 32'(nsigma) * 32'(noise_cal[an]);
                if (peak8 > thr8 && peak4 > base_cal[an]) begin
                    diff = peak4 - base_cal[an];
                    r.hit = 1'b1;
                    r.peak_above_base = diff;
                    acc = {1'b0, amp_sum[an]} + 33'(diff);
                    amp_sum[an] = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
                    acc = 33'(bin_sum[an]) + 33'(run_bin);
                    bin_sum[an] = (acc > 33'hFF_FFFF) ? 24'hFF_FFFF : acc[23:0];
                    if (evt_count[an] != 16'hFFFF) evt_count[an]++;
                end
            end
            r.sum_amplitude = amp_sum[an];
            r.sum_time_bins = bin_sum[an];
            r.hit_count     = evt_count[an];
            r.anode_good    = good_cal[an];
            expected_peaks.push_back(r);
            run_max = '0;
            run_bin = '0;
        endfunction

        task check_result(tppa_pkg::t_res got);
            tppa_pkg::t_res want;
            if (expected_peaks.size() == 0) begin
                report("unexpected result, anode", got.anode_out, 0);
                return;
            end
            want = expected_peaks.pop_front();
            checked++;
            if (got.hit) hits_seen++;
            if (got.anode_out !== want.anode_out)
                report("anode_out", got.anode_out, want.anode_out);
            if (got.hit !== want.hit) report("hit", got.hit, want.hit);
            if (got.peak_above_base !== want.peak_above_base)
                report("peak_above_base", got.peak_above_base, want.peak_above_base);
            if (got.peak_bin !== want.peak_bin)
                report("peak_bin", got.peak_bin, want.peak_bin);
            if (got.sum_amplitude !== want.sum_amplitude)
                report("sum_amplitude", got.sum_amplitude, want.sum_amplitude);
            if (got.sum_time_bins !== want.sum_time_bins)
                report("sum_time_bins", got.sum_time_bins, want.sum_time_bins);
            if (got.hit_count !== want.hit_count)
                report("hit_count", got.hit_count, want.hit_count);
            if (got.anode_good !== want.anode_good)
                report("anode_good", got.anode_good, want.anode_good);
        endtask

        task check_leftovers();
            if (expected_peaks.size() != 0)
                report("results never delivered, count", expected_peaks.size(), 0);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_func = '0;
    logic [7:0]  i_anode = '0;
    logic [7:0]  i_time_bin = '0;
    logic [9:0]  i_sample = '0;
    logic        i_last = 1'b0;
    logic [13:0] i_cal_baseline = '0;
    logic [13:0] i_cal_noise = '0;
    logic        i_cal_good = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_anode_out;
    logic        o_hit;
    logic [13:0] o_peak_above_base;
    logic [7:0]  o_peak_bin;
    logic [31:0] o_sum_amplitude;
    logic [23:0] o_sum_time_bins;
    logic [15:0] o_hit_count;
    logic        o_anode_good;

    peak_sum_scoreboard sb = new();
    int          idle_pct = 33;
    int unsigned items_sent = 0;
    int unsigned reg_writes = 0;
    logic [7:0]  anode_pool [8];

    test_pulse_peak_accumulator dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // The result side pops at random; a transaction happens on pop with !empty.
    initial begin
        forever begin
            @(negedge i_clk);
            pop <= i_rst_n && ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        tppa_pkg::t_res got;
        if (i_rst_n && pop && !empty) begin
            got.anode_out       = o_anode_out;
            got.hit             = o_hit;
            got.peak_above_base = o_peak_above_base;
            got.peak_bin        = o_peak_bin;
            got.sum_amplitude   = o_sum_amplitude;
            got.sum_time_bins   = o_sum_time_bins;
            got.hit_count       = o_hit_count;
            got.anode_good      = o_anode_good;
            sb.check_result(got);
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [7:0] an,
                             input logic [7:0] tb, input logic [9:0] smp,
                             input logic last, input logic [13:0] cb,
                             input logic [13:0] cn, input logic cg);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push           <= 1'b1;
        i_func         <= func;
        i_anode        <= an;
        i_time_bin     <= tb;
        i_sample       <= smp;
        i_last         <= last;
        i_cal_baseline <= cb;
        i_cal_noise    <= cn;
        i_cal_good     <= cg;
        do @(posedge i_clk); while (full);
        sb.accept_item(func, an, tb, smp, last, cb, cn, cg);
        if (func != FUNC_UNUSED) items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, value);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads leave nothing in the result queue, so an empty scoreboard alone
    // does not mean the pipeline is quiet.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [7:0] ns, input logic [7:0] lo,
                              input logic [7:0] hi);
        write_reg(tppa_pkg::CFG_NSIGMA, ns);
        write_reg(tppa_pkg::CFG_FIRST_BIN, lo);
        write_reg(tppa_pkg::CFG_LAST_BIN, hi);
    endtask

    task automatic load_random(input logic [7:0] an);
        logic [13:0] cb;
        logic [13:0] cn;
        if ($urandom_range(99) < 30) begin
            cb = 14'($urandom);
            cn = 14'($urandom);
        end else begin
            cb = 14'($urandom_range(0, 1200));
            cn = 14'($urandom_range(0, 96));
        end
        send_item(tppa_pkg::FUNC_LOAD, an, 8'($urandom), 10'($urandom), 1'($urandom),
                  cb, cn, $urandom_range(99) < 85);
    endtask

    // One anode's samples in non-decreasing bin order, closed by the last flag.
    task automatic send_anode(input logic [7:0] an);
        int         nsamp;
        int         bin;
        logic [9:0] smp;
        nsamp = $urandom_range(1, 10);
        bin   = $urandom_range(0, 255);
        smp   = '0;
        for (int k = 0; k < nsamp; k++) begin
            if (k == 0 || $urandom_range(99) >= 10) begin
                if ($urandom_range(99) < 60) smp = 10'($urandom_range(0, 63));
                else smp = 10'($urandom);
            end
            send_item(tppa_pkg::FUNC_SAMPLE, an, 8'(bin), smp, k == nsamp - 1,
                      14'($urandom), 14'($urandom), 1'($urandom));
            bin = bin + $urandom_range(1, 4);
            if (bin > 255) bin = 255;
        end
    endtask

    function automatic logic [7:0] pick_anode();
        if ($urandom_range(99) < 70) return anode_pool[$urandom_range(0, 7)];
        return 8'($urandom);
    endfunction

    task automatic random_item();
        int          choice;
        logic [7:0]  an;
        choice = $urandom_range(99);
        an     = pick_anode();
        if (choice < 70) begin
            if ($urandom_range(99) < 20) load_random(an);
            send_anode(an);
            if ($urandom_range(99) < 10)
                send_item(tppa_pkg::FUNC_READ, an, '0, '0, 1'b0, '0, '0, 1'b0);
        end else if (choice < 78) begin
            send_item(tppa_pkg::FUNC_READ, an, 8'($urandom), 10'($urandom), 1'($urandom),
                      14'($urandom), 14'($urandom), 1'($urandom));
        end else if (choice < 86) begin
            load_random(an);
        end else begin
            // Noise: any code, any fields, possibly a sequence left open.
            send_item(2'($urandom), an, 8'($urandom), 10'($urandom), 1'($urandom),
                      14'($urandom), 14'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        anode_pool[0] = 8'd0;
        anode_pool[1] = 8'd255;
        for (int i = 2; i < 8; i++) anode_pool[i] = 8'($urandom);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: reset contents, extremes, ties and the odd codes.
        send_item(tppa_pkg::FUNC_READ, 8'd0, '0, '0, 1'b0, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd0, 8'd0, 10'd0, 1'b0, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd0, 8'd1, 10'd1023, 1'b0, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd0, 8'd2, 10'd1023, 1'b0, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd0, 8'd255, 10'd5, 1'b1, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_LOAD, 8'd255, 8'd255, 10'd1023, 1'b1,
                  14'h3FFF, 14'h3FFF, 1'b1);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd255, 8'd255, 10'd1023, 1'b1, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_LOAD, 8'd7, '0, '0, 1'b0, 14'd0, 14'd0, 1'b0);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd7, 8'd10, 10'd900, 1'b1, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_LOAD, 8'd3, '0, '0, 1'b0, 14'd0, 14'd0, 1'b1);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd3, 8'd20, 10'd0, 1'b1, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd3, 8'd21, 10'd1023, 1'b1, '0, '0, 1'b0);
        send_item(FUNC_UNUSED, 8'd3, 8'd21, 10'd1023, 1'b1, 14'h3FFF, 14'h3FFF, 1'b1);
        send_item(tppa_pkg::FUNC_READ, 8'd3, '0, '0, 1'b0, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_READ, 8'd255, 8'hFF, 10'h3FF, 1'b1,
                  14'h3FFF, 14'h3FFF, 1'b1);
        send_item(tppa_pkg::FUNC_READ, 8'd7, '0, '0, 1'b0, '0, '0, 1'b0);
        drain();
        // Empty window: first bin above last bin.
        set_window(8'd255, 8'd200, 8'd100);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd0, 8'd150, 10'd800, 1'b0, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd0, 8'd210, 10'd900, 1'b1, '0, '0, 1'b0);
        drain();
        set_window(8'd0, 8'd255, 8'd255);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd0, 8'd254, 10'd1000, 1'b0, '0, '0, 1'b0);
        send_item(tppa_pkg::FUNC_SAMPLE, 8'd0, 8'd255, 10'd30, 1'b1, '0, '0, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            logic [7:0] lo;
            drain();
            lo = 8'($urandom_range(0, 127));
            case (p)
                0: set_window(tppa_pkg::NSIGMA_AT_RESET, 8'd0, 8'd255);
                1: set_window(8'd255, 8'd0, 8'd255);
                2: set_window(8'd0, 8'd0, 8'd255);
                3: set_window(8'($urandom), lo, lo);
                4: set_window(8'($urandom), lo, 8'($urandom_range(128, 255)));
                default: set_window(8'($urandom_range(0, 64)), 8'd0, 8'd255);
            endcase
            idle_pct = (p == 2) ? 0 : 33;
            while (items_sent < (p + 1) * PHASE_ITEMS) random_item();
            // Close any sequence a noise item left open before the next setting.
            send_item(tppa_pkg::FUNC_SAMPLE, pick_anode(), 8'($urandom), 10'($urandom),
                      1'b1, '0, '0, 1'b0);
        end

        drain();
        sb.check_leftovers();
        $display("Covered %0d input transactions and %0d register writes over %0d phases.",
                 items_sent, reg_writes, PHASES);
        $display("Checked %0d results, %0d of them hits, with %0d mismatches.",
                 sb.checked, sb.hits_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
